FILE: sv/sabwt_pkg.sv
// Shared constants, step codes and control structs for the suffix array builder.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package sabwt_pkg;

  localparam int MAX_LEN      = 1024;
  localparam int AW           = $clog2(MAX_LEN);
  localparam int LW           = AW + 1;
  localparam int BUCKETS      = MAX_LEN + 1;
  localparam int BYTE_BUCKETS = 257;
  localparam int SW           = 8;

  localparam logic [1:0] RES_BUILT = 2'd0;
  localparam logic [1:0] RES_QOK   = 2'd1;
  localparam logic [1:0] RES_BAD   = 2'd2;
  localparam logic [1:0] RES_OVF   = 2'd3;

  typedef enum logic [4:0] {
    STEP_IDLE, STEP_Q_SA, STEP_Q_TX, STEP_I_RD, STEP_I_WR, STEP_ROUND,
    STEP_CLR, STEP_CNT_J, STEP_CNT_K, STEP_CNT_C, STEP_CNT_W,
    STEP_PRE, STEP_PRE_W, STEP_PL_J, STEP_PL_K, STEP_PL_C, STEP_PL_W,
    STEP_RR_SA, STEP_RR_R1, STEP_RR_R2, STEP_RR_W, STEP_CP, STEP_CP_W,
    STEP_OUT
  } step_t;

  typedef struct packed {
    step_t step;
    logic  accept;
  } sabwt_cmd_t;

  typedef struct packed {
    logic acc_func;
    logic acc_last;
    logic acc_full;
    logic acc_qbad;
    logic i_eq_n;
    logic i_zero;
    logic i_lastb;
    logic t_lt_n;
    logic pass_b;
    logic out_free;
  } sabwt_stat_t;

endpackage

FILE: sv/suffix_array_bwt_builder_top.sv
// Top level of the suffix array and BWT builder: sequencer plus datapath.
// Depends on sabwt_pkg, sabwt_ctrl and sabwt_dp.
//
//   channel  handshake              word fields
//   in       in_valid / in_ready    in_func, in_symbol, in_last, in_rank
//   out      out_valid / out_ready  out_status, out_suffix_start, out_bwt_symbol,
//                                   out_text_length
//
// An append is taken straight from idle; a query reads the suffix order, then the text,
// before its word is registered. A build over n bytes uses a bucket range L = max(257, n+1)
// and R doubling rounds; its length is set by one read port per memory.
// in_ready drops for the whole build; a word held by out_ready lets plain appends
// through but holds the next result, and in_ready with it, until it is taken.
// Reset is synchronous; memories are not cleared and are written before they are read.
`timescale 1ns / 1ps

module suffix_array_bwt_builder_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_func,
  input  logic [sabwt_pkg::SW-1:0]     in_symbol,
  input  logic                         in_last,
  input  logic [sabwt_pkg::AW-1:0]     in_rank,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic [sabwt_pkg::AW-1:0]     out_suffix_start,
  output logic [sabwt_pkg::SW-1:0]     out_bwt_symbol,
  output logic [sabwt_pkg::LW-1:0]     out_text_length
);

  sabwt_pkg::sabwt_cmd_t  cmd;
  sabwt_pkg::sabwt_stat_t stat;

  sabwt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sabwt_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_func          (in_func),
    .in_symbol        (in_symbol),
    .in_last          (in_last),
    .in_rank          (in_rank),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_suffix_start (out_suffix_start),
    .out_bwt_symbol   (out_bwt_symbol),
    .out_text_length  (out_text_length)
  );

endmodule

FILE: sv/sabwt_ctrl.sv
// Sequencer for loads, queries and the prefix doubling build.
// Depends on sabwt_pkg; drives sabwt_dp through a command struct.
`timescale 1ns / 1ps

module sabwt_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sabwt_pkg::sabwt_stat_t stat,
  output sabwt_pkg::sabwt_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_Q_SA, S_Q_TX, S_I_RD, S_I_WR, S_ROUND,
    S_CLR, S_CNT_J, S_CNT_K, S_CNT_C, S_CNT_W,
    S_PRE, S_PRE_W, S_PL_J, S_PL_K, S_PL_C, S_PL_W,
    S_RR_SA, S_RR_R1, S_RR_R2, S_RR_W, S_CP, S_CP_W, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;
  logic   accept;

  assign in_ready = in_ready_r;
  assign accept   = in_valid & in_ready_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (stat.acc_func) state_nxt = stat.acc_qbad ? S_OUT : S_Q_SA;
          else if (stat.acc_last) state_nxt = S_I_RD;
          else if (stat.acc_full) state_nxt = S_OUT;
        end
      end
      S_Q_SA:  state_nxt = S_Q_TX;
      S_Q_TX:  state_nxt = S_OUT;
      S_I_RD:  state_nxt = stat.i_eq_n ? S_ROUND : S_I_WR;
      S_I_WR:  state_nxt = S_I_RD;
      S_ROUND: state_nxt = stat.t_lt_n ? S_CLR : S_OUT;
      S_CLR:   state_nxt = stat.i_lastb ? S_CNT_J : S_CLR;
      S_CNT_J: state_nxt = stat.i_eq_n ? S_PRE : S_CNT_K;
      S_CNT_K: state_nxt = S_CNT_C;
      S_CNT_C: state_nxt = S_CNT_W;
      S_CNT_W: state_nxt = S_CNT_J;
      S_PRE:   state_nxt = S_PRE_W;
      S_PRE_W: state_nxt = stat.i_lastb ? S_PL_J : S_PRE;
      S_PL_J: begin
        if (stat.i_zero) state_nxt = stat.pass_b ? S_RR_SA : S_CLR;
        else state_nxt = S_PL_K;
      end
      S_PL_K:  state_nxt = S_PL_C;
      S_PL_C:  state_nxt = S_PL_W;
      S_PL_W:  state_nxt = S_PL_J;
      S_RR_SA: state_nxt = stat.i_eq_n ? S_CP : S_RR_R1;
      S_RR_R1: state_nxt = S_RR_R2;
      S_RR_R2: state_nxt = S_RR_W;
      S_RR_W:  state_nxt = S_RR_SA;
      S_CP:    state_nxt = stat.i_eq_n ? S_ROUND : S_CP_W;
      S_CP_W:  state_nxt = S_CP;
      S_OUT:   state_nxt = stat.out_free ? S_IDLE : S_OUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.accept = accept;
    case (state_r)
      S_IDLE:  cmd.step = sabwt_pkg::STEP_IDLE;
      S_Q_SA:  cmd.step = sabwt_pkg::STEP_Q_SA;
      S_Q_TX:  cmd.step = sabwt_pkg::STEP_Q_TX;
      S_I_RD:  cmd.step = sabwt_pkg::STEP_I_RD;
      S_I_WR:  cmd.step = sabwt_pkg::STEP_I_WR;
      S_ROUND: cmd.step = sabwt_pkg::STEP_ROUND;
      S_CLR:   cmd.step = sabwt_pkg::STEP_CLR;
      S_CNT_J: cmd.step = sabwt_pkg::STEP_CNT_J;
      S_CNT_K: cmd.step = sabwt_pkg::STEP_CNT_K;
      S_CNT_C: cmd.step = sabwt_pkg::STEP_CNT_C;
      S_CNT_W: cmd.step = sabwt_pkg::STEP_CNT_W;
      S_PRE:   cmd.step = sabwt_pkg::STEP_PRE;
      S_PRE_W: cmd.step = sabwt_pkg::STEP_PRE_W;
      S_PL_J:  cmd.step = sabwt_pkg::STEP_PL_J;
      S_PL_K:  cmd.step = sabwt_pkg::STEP_PL_K;
      S_PL_C:  cmd.step = sabwt_pkg::STEP_PL_C;
      S_PL_W:  cmd.step = sabwt_pkg::STEP_PL_W;
      S_RR_SA: cmd.step = sabwt_pkg::STEP_RR_SA;
      S_RR_R1: cmd.step = sabwt_pkg::STEP_RR_R1;
      S_RR_R2: cmd.step = sabwt_pkg::STEP_RR_R2;
      S_RR_W:  cmd.step = sabwt_pkg::STEP_RR_W;
      S_CP:    cmd.step = sabwt_pkg::STEP_CP;
      S_CP_W:  cmd.step = sabwt_pkg::STEP_CP_W;
      S_OUT:   cmd.step = sabwt_pkg::STEP_OUT;
      default: cmd.step = sabwt_pkg::STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

endmodule

FILE: sv/sabwt_dp.sv
// Datapath: text, rank, order and bucket memories, loop counters, result register.
// Depends on sabwt_pkg; stepped by sabwt_ctrl through the command struct.
`timescale 1ns / 1ps

module sabwt_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sabwt_pkg::sabwt_cmd_t          cmd,
  output sabwt_pkg::sabwt_stat_t         stat,
  input  logic                           in_func,
  input  logic [sabwt_pkg::SW-1:0]       in_symbol,
  input  logic                           in_last,
  input  logic [sabwt_pkg::AW-1:0]       in_rank,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [1:0]                     out_status,
  output logic [sabwt_pkg::AW-1:0]       out_suffix_start,
  output logic [sabwt_pkg::SW-1:0]       out_bwt_symbol,
  output logic [sabwt_pkg::LW-1:0]       out_text_length
);

  localparam int AW = sabwt_pkg::AW;
  localparam int LW = sabwt_pkg::LW;
  localparam int SW = sabwt_pkg::SW;

  logic [SW-1:0] text_mem [sabwt_pkg::MAX_LEN];
  logic [LW-1:0] rank_mem [sabwt_pkg::MAX_LEN+1];
  logic [LW-1:0] next_mem [sabwt_pkg::MAX_LEN];
  logic [AW-1:0] sa_mem   [sabwt_pkg::MAX_LEN];
  logic [AW-1:0] sa2_mem  [sabwt_pkg::MAX_LEN];
  logic [LW-1:0] cnt_mem  [sabwt_pkg::BUCKETS];

  logic [SW-1:0] text_rd;
  logic [LW-1:0] rank_rd, next_rd, cnt_rd;
  logic [AW-1:0] sa_rd, sa2_rd;

  logic          text_we, rank_we, next_we, sa_we, sa2_we, cnt_we;
  logic [AW-1:0] text_wa, text_ra, sa_wa, sa_ra, sa2_wa, sa2_ra, next_ra;
  logic [LW-1:0] rank_wa, rank_ra, cnt_wa, cnt_ra, rank_wd, cnt_wd, next_wd;
  logic [AW-1:0] sa_wd;

  logic [LW-1:0] len_r, i_r, t_r, acc_r, key_r, r1_r, prev_r1_r, prev_r2_r, prev_v_r;
  logic [AW-1:0] j_r, c_r, s_r;
  logic          built_r, pass_r;
  logic [1:0]    res_status_r;
  logic [AW-1:0] res_start_r;
  logic [SW-1:0] res_bwt_r;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [AW-1:0] out_start_r;
  logic [SW-1:0] out_bwt_r;
  logic [LW-1:0] out_len_r;

  logic [LW-1:0] elen, lim_m1, im1, newv, kaddr, pos_full;
  logic [AW-1:0] j_now, qprev;
  logic          acc_full, less;

  // Second-key index clamped to the end sentinel at the text length.
  function automatic logic [LW-1:0] clamp_key(input logic [AW-1:0] j,
                                              input logic [LW-1:0] t,
                                              input logic [LW-1:0] n);
    logic [LW:0] sum;
    sum = {2'b00, j} + {1'b0, t};
    return (sum < {1'b0, n}) ? sum[LW-1:0] : n;
  endfunction

  function automatic logic [AW-1:0] im1_len(input logic [LW-1:0] n);
    logic [LW-1:0] d;
    d = n - LW'(1);
    return d[AW-1:0];
  endfunction

  assign elen     = built_r ? '0 : len_r;
  assign acc_full = (elen == LW'(sabwt_pkg::MAX_LEN));
  assign lim_m1   = (len_r > LW'(sabwt_pkg::BYTE_BUCKETS - 1)) ? len_r
                                                               : LW'(sabwt_pkg::BYTE_BUCKETS - 1);
  assign im1      = i_r - LW'(1);
  assign pos_full = cnt_rd - LW'(1);
  assign qprev    = (sa_rd == '0) ? im1_len(len_r) : sa_rd - AW'(1);

  always_comb begin
    if (pass_r) j_now = sa2_rd;
    else if (cmd.step == sabwt_pkg::STEP_CNT_K) j_now = i_r[AW-1:0];
    else j_now = im1[AW-1:0];
  end

  assign kaddr = pass_r ? {1'b0, j_now} : clamp_key(j_now, t_r, len_r);

  assign less = (prev_r1_r != r1_r) ? (prev_r1_r < r1_r) : (prev_r2_r < rank_rd);
  assign newv = (i_r == '0) ? LW'(1) : prev_v_r + {{(LW-1){1'b0}}, less};

  always_comb begin
    stat.acc_func = in_func;
    stat.acc_last = in_last;
    stat.acc_full = acc_full;
    stat.acc_qbad = !built_r || ({1'b0, in_rank} >= len_r);
    stat.i_eq_n   = (i_r == len_r);
    stat.i_zero   = (i_r == '0);
    stat.i_lastb  = (i_r == lim_m1);
    stat.t_lt_n   = (t_r < len_r);
    stat.pass_b   = pass_r;
    stat.out_free = !out_valid_r || out_ready;
  end

  // Memory port selection per step.
  always_comb begin
    text_we = 1'b0; text_wa = elen[AW-1:0]; text_ra = i_r[AW-1:0];
    rank_we = 1'b0; rank_wa = i_r; rank_wd = {{(LW-SW){1'b0}}, text_rd}; rank_ra = kaddr;
    next_we = 1'b0; next_wd = newv; next_ra = i_r[AW-1:0];
    sa_we   = 1'b0; sa_wa = i_r[AW-1:0]; sa_wd = i_r[AW-1:0]; sa_ra = in_rank;
    sa2_we  = 1'b0; sa2_wa = pos_full[AW-1:0]; sa2_ra = i_r[AW-1:0];
    cnt_we  = 1'b0; cnt_wa = i_r; cnt_wd = '0; cnt_ra = rank_rd;
    case (cmd.step)
      sabwt_pkg::STEP_IDLE: begin
        text_we = cmd.accept && !in_func && !acc_full;
      end
      sabwt_pkg::STEP_Q_SA: text_ra = qprev;
      sabwt_pkg::STEP_I_RD: begin
        if (i_r == len_r) begin
          rank_we = 1'b1;
          rank_wa = len_r;
          rank_wd = '0;
        end
      end
      sabwt_pkg::STEP_I_WR: begin
        rank_we = 1'b1;
        sa_we   = 1'b1;
      end
      sabwt_pkg::STEP_CLR: cnt_we = 1'b1;
      sabwt_pkg::STEP_CNT_W: begin
        cnt_we = 1'b1;
        cnt_wa = key_r;
        cnt_wd = cnt_rd + LW'(1);
      end
      sabwt_pkg::STEP_PRE: cnt_ra = i_r;
      sabwt_pkg::STEP_PRE_W: begin
        cnt_we = 1'b1;
        cnt_wd = acc_r + cnt_rd;
      end
      sabwt_pkg::STEP_PL_J: sa2_ra = im1[AW-1:0];
      sabwt_pkg::STEP_PL_W: begin
        cnt_we = 1'b1;
        cnt_wa = key_r;
        cnt_wd = pos_full;
        sa_we  = pass_r;
        sa_wa  = pos_full[AW-1:0];
        sa_wd  = j_r;
        sa2_we = !pass_r;
      end
      sabwt_pkg::STEP_RR_SA: sa_ra = i_r[AW-1:0];
      sabwt_pkg::STEP_RR_R1: rank_ra = {1'b0, sa_rd};
      sabwt_pkg::STEP_RR_R2: rank_ra = clamp_key(c_r, t_r, len_r);
      sabwt_pkg::STEP_RR_W:  next_we = 1'b1;
      sabwt_pkg::STEP_CP_W: begin
        rank_we = 1'b1;
        rank_wd = next_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (text_we) text_mem[text_wa] <= in_symbol;
    text_rd <= text_mem[text_ra];
  end

  always_ff @(posedge clk) begin
    if (rank_we) rank_mem[rank_wa] <= rank_wd;
    rank_rd <= rank_mem[rank_ra];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[c_r] <= next_wd;
    next_rd <= next_mem[next_ra];
  end

  always_ff @(posedge clk) begin
    if (sa_we) sa_mem[sa_wa] <= sa_wd;
    sa_rd <= sa_mem[sa_ra];
  end

  always_ff @(posedge clk) begin
    if (sa2_we) sa2_mem[sa2_wa] <= j_r;
    sa2_rd <= sa2_mem[sa2_ra];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_rd <= cnt_mem[cnt_ra];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.step == sabwt_pkg::STEP_IDLE && cmd.accept && !in_func) begin
        built_r <= 1'b0;
        len_r   <= acc_full ? elen : elen + LW'(1);
      end
      if (cmd.step == sabwt_pkg::STEP_ROUND && !(t_r < len_r)) built_r <= 1'b1;
      if (cmd.step == sabwt_pkg::STEP_OUT && stat.out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Loop counters and working registers.
  always_ff @(posedge clk) begin
    case (cmd.step)
      sabwt_pkg::STEP_IDLE: begin
        if (cmd.accept) begin
          i_r         <= '0;
          t_r         <= LW'(1);
          res_start_r <= '0;
          res_bwt_r   <= '0;
          if (in_func) res_status_r <= stat.acc_qbad ? sabwt_pkg::RES_BAD : sabwt_pkg::RES_QOK;
          else res_status_r <= acc_full ? sabwt_pkg::RES_OVF : sabwt_pkg::RES_BUILT;
        end
      end
      sabwt_pkg::STEP_Q_SA: s_r <= sa_rd;
      sabwt_pkg::STEP_Q_TX: begin
        res_start_r <= s_r;
        res_bwt_r   <= text_rd;
      end
      sabwt_pkg::STEP_I_WR: i_r <= i_r + LW'(1);
      sabwt_pkg::STEP_ROUND: begin
        pass_r <= 1'b0;
        i_r    <= '0;
      end
      sabwt_pkg::STEP_CLR: i_r <= stat.i_lastb ? '0 : i_r + LW'(1);
      sabwt_pkg::STEP_CNT_J: begin
        if (stat.i_eq_n) begin
          i_r   <= '0;
          acc_r <= '0;
        end
      end
      sabwt_pkg::STEP_CNT_K: j_r <= j_now;
      sabwt_pkg::STEP_CNT_C: key_r <= rank_rd;
      sabwt_pkg::STEP_CNT_W: i_r <= i_r + LW'(1);
      sabwt_pkg::STEP_PRE_W: begin
        acc_r <= acc_r + cnt_rd;
        i_r   <= stat.i_lastb ? len_r : i_r + LW'(1);
      end
      sabwt_pkg::STEP_PL_J: begin
        if (stat.i_zero) pass_r <= 1'b1;
      end
      sabwt_pkg::STEP_PL_K: j_r <= j_now;
      sabwt_pkg::STEP_PL_C: key_r <= rank_rd;
      sabwt_pkg::STEP_PL_W: i_r <= im1;
      sabwt_pkg::STEP_RR_SA: begin
        if (stat.i_eq_n) i_r <= '0;
      end
      sabwt_pkg::STEP_RR_R1: c_r <= sa_rd;
      sabwt_pkg::STEP_RR_R2: r1_r <= rank_rd;
      sabwt_pkg::STEP_RR_W: begin
        prev_r1_r <= r1_r;
        prev_r2_r <= rank_rd;
        prev_v_r  <= newv;
        i_r       <= i_r + LW'(1);
      end
      sabwt_pkg::STEP_CP: begin
        if (stat.i_eq_n) begin
          i_r <= '0;
          t_r <= {t_r[LW-2:0], 1'b0};
        end
      end
      sabwt_pkg::STEP_CP_W: i_r <= i_r + LW'(1);
      sabwt_pkg::STEP_OUT: begin
        if (stat.out_free) begin
          out_status_r <= res_status_r;
          out_start_r  <= res_start_r;
          out_bwt_r    <= res_bwt_r;
          out_len_r    <= len_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_suffix_start = out_start_r;
  assign out_bwt_symbol   = out_bwt_r;
  assign out_text_length  = out_len_r;

endmodule

FILE: sv/sabwt_chk.sv
// Port-level checker for the suffix array builder, bound to the top level.
// Depends on sabwt_pkg and suffix_array_bwt_builder_top.
`timescale 1ns / 1ps

module sabwt_chk (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [1:0]               out_status,
  input logic [sabwt_pkg::AW-1:0] out_suffix_start,
  input logic [sabwt_pkg::SW-1:0] out_bwt_symbol,
  input logic [sabwt_pkg::LW-1:0] out_text_length
);

  // A stalled word keeps its status.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result word changed while stalled");

  // A good query names a suffix inside the text.
  a_qrange: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == sabwt_pkg::RES_QOK |-> out_suffix_start < out_text_length)
    else $error("query result beyond text length");

  // Overflow only reports a full text.
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == sabwt_pkg::RES_OVF
      |-> out_text_length == sabwt_pkg::LW'(sabwt_pkg::MAX_LEN))
    else $error("overflow reported on a text that is not full");

  // Only a good query carries suffix data.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != sabwt_pkg::RES_QOK
      |-> out_suffix_start == '0 && out_bwt_symbol == '0)
    else $error("non-query result carries suffix data");

endmodule

bind suffix_array_bwt_builder_top sabwt_chk u_sabwt_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_suffix_start (out_suffix_start),
  .out_bwt_symbol   (out_bwt_symbol),
  .out_text_length  (out_text_length)
);

FILE: dv/suffix_array_bwt_builder_top_tb.sv
// Testbench for suffix_array_bwt_builder_top: directed and random texts, queries and overflow.
// Depends on sabwt_pkg and the RTL; results are checked against a prefix-doubling predictor.
`timescale 1ns / 1ps

module suffix_array_bwt_builder_top_tb;

  localparam int AW           = sabwt_pkg::AW;
  localparam int SW           = sabwt_pkg::SW;
  localparam int LW           = sabwt_pkg::LW;
  localparam int MAX_LEN      = sabwt_pkg::MAX_LEN;
  localparam int BUCKETS      = sabwt_pkg::BUCKETS;
  localparam int BYTE_BUCKETS = sabwt_pkg::BYTE_BUCKETS;

  localparam int LIMIT_CYCLES = 3_000_000;

  typedef struct {
    logic [1:0]    status;
    logic [AW-1:0] start;
    logic [SW-1:0] bwt;
    logic [LW-1:0] len;
  } sa_word_t;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  logic          in_func;
  logic [SW-1:0] in_symbol;
  logic          in_last;
  logic [AW-1:0] in_rank;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [1:0]    out_status;
  logic [AW-1:0] out_suffix_start;
  logic [SW-1:0] out_bwt_symbol;
  logic [LW-1:0] out_text_length;

  suffix_array_bwt_builder_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_symbol(in_symbol), .in_last(in_last), .in_rank(in_rank),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_suffix_start(out_suffix_start), .out_bwt_symbol(out_bwt_symbol),
    .out_text_length(out_text_length)
  );

  // Predictor state.
  logic [7:0]  txt[MAX_LEN];
  int unsigned grp[MAX_LEN + 1];
  int unsigned nxt[MAX_LEN + 1];
  int unsigned sa[MAX_LEN];
  int unsigned sk_order[MAX_LEN];
  int unsigned cnt[BUCKETS];
  int unsigned n_loaded;
  bit          built;

  sa_word_t    pending_words[$];
  int          mismatches = 0;
  int          words_seen = 0;
  int          items_sent;
  int          builds_done;
  longint      cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned bucket_of(int unsigned v, int unsigned lim);
    return (v < lim) ? v : lim - 1;
  endfunction

  function automatic int unsigned second_rank(int unsigned i, int unsigned t, int unsigned n);
    int unsigned k;
    k = i + t;
    return grp[(k < n) ? k : n];
  endfunction

  function automatic void counting_pass(int unsigned n, int unsigned lim, int unsigned t,
                                        bit by_second);
    int unsigned i, b, j;
    for (i = 0; i < BUCKETS; i++) cnt[i] = 0;
    for (i = 0; i < n; i++) begin
      b = bucket_of(by_second ? second_rank(i, t, n) : grp[sk_order[i]], lim);
      cnt[b]++;
    end
    for (i = 1; i < lim; i++) cnt[i] += cnt[i - 1];
    for (i = n; i > 0; i--) begin
      j = by_second ? (i - 1) : sk_order[i - 1];
      b = bucket_of(by_second ? second_rank(j, t, n) : grp[j], lim);
      cnt[b]--;
      if (cnt[b] < MAX_LEN) begin
        if (by_second) sk_order[cnt[b]] = j;
        else sa[cnt[b]] = j;
      end
    end
  endfunction

  function automatic void build_suffix_order();
    int unsigned n, lim, i, t, a, c;
    bit less;
    n = n_loaded;
    lim = (n + 1 > BYTE_BUCKETS) ? n + 1 : BYTE_BUCKETS;
    if (lim > BUCKETS) lim = BUCKETS;
    for (i = 0; i < n; i++) begin
      sa[i] = i;
      grp[i] = txt[i];
    end
    grp[n] = 0;
    nxt[n] = 0;
    for (t = 1; t < n; t = t << 1) begin
      counting_pass(n, lim, t, 1'b1);
      counting_pass(n, lim, t, 1'b0);
      nxt[sa[0]] = 1;
      for (i = 1; i < n; i++) begin
        a = sa[i - 1];
        c = sa[i];
        if (grp[a] == grp[c]) less = second_rank(a, t, n) < second_rank(c, t, n);
        else less = grp[a] < grp[c];
        nxt[c] = nxt[a] + (less ? 1 : 0);
      end
      for (i = 0; i < n; i++) grp[i] = nxt[i];
      grp[n] = 0;
    end
    built = 1'b1;
    builds_done++;
  endfunction

  // Works out the word (if any) that one accepted input causes.
  function automatic void predict_word(logic func, logic [7:0] sym, logic lst,
                                       logic [AW-1:0] rk);
    sa_word_t w;
    bit ovf;
    int unsigned s, p;
    w.status = sabwt_pkg::RES_BUILT;
    w.start  = '0;
    w.bwt    = '0;
    ovf = 1'b0;
    if (!func) begin
      if (built) begin
        built = 1'b0;
        n_loaded = 0;
      end
      if (n_loaded < MAX_LEN) begin
        txt[n_loaded] = sym;
        n_loaded++;
      end else begin
        ovf = 1'b1;
      end
      if (lst) build_suffix_order();
      if (!lst && !ovf) return;
      w.status = ovf ? sabwt_pkg::RES_OVF : sabwt_pkg::RES_BUILT;
    end else if (!built || rk >= n_loaded) begin
      w.status = sabwt_pkg::RES_BAD;
    end else begin
      s = sa[rk];
      p = (s == 0) ? n_loaded - 1 : s - 1;
      w.status = sabwt_pkg::RES_QOK;
      w.start  = s[AW-1:0];
      w.bwt    = txt[p];
    end
    w.len = n_loaded[LW-1:0];
    pending_words.insert(pending_words.size(), w);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_word(logic func, logic [7:0] sym, logic lst, logic [AW-1:0] rk);
    int gap;
    in_valid  <= 1'b1;
    in_func   <= func;
    in_symbol <= sym;
    in_last   <= lst;
    in_rank   <= rk;
    do @(posedge clk); while (!in_ready);
    predict_word(func, sym, lst, rk);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_text(input logic [7:0] bytes[$]);
    int i;
    for (i = 0; i < bytes.size(); i++) send_word(1'b0, bytes[i], i == bytes.size() - 1, '0);
  endtask

  task automatic query_all(int n);
    int r;
    for (r = 0; r < n; r++) send_word(1'b1, 8'($urandom), 1'b0, AW'(r));
  endtask

  // Bad queries before any build, single byte, repeats, zero and 0xFF bytes.
  task automatic test_directed();
    send_word(1'b1, 8'h00, 1'b0, '0);
    send_word(1'b1, 8'hff, 1'b1, '1);
    load_text('{8'h41});
    query_all(2);
    load_text('{8'h62, 8'h61, 8'h6e, 8'h61, 8'h6e, 8'h61});
    query_all(6);
    send_word(1'b1, 8'h00, 1'b0, 10'd6);
    load_text('{8'hff, 8'hff, 8'h00, 8'h01});
    query_all(4);
    send_word(1'b0, 8'h61, 1'b0, '0);
    // Query while a text is being loaded: not built.
    send_word(1'b1, 8'h00, 1'b0, '0);
    send_word(1'b0, 8'h61, 1'b1, '1);
  endtask

  // Fill to capacity, push two more bytes (the second one last), then query.
  task automatic test_overflow();
    int i;
    for (i = 0; i < MAX_LEN; i++) send_word(1'b0, 8'($urandom_range(1, 4)), 1'b0, '0);
    send_word(1'b0, 8'h55, 1'b0, '0);
    send_word(1'b0, 8'haa, 1'b1, '0);
    for (i = 0; i < 12; i++) send_word(1'b1, 8'h00, 1'b0, AW'($urandom_range(0, 1023)));
    send_word(1'b1, 8'h00, 1'b0, AW'(MAX_LEN - 1));
    send_word(1'b1, 8'h00, 1'b0, '0);
  endtask

  task automatic test_random(int target);
    int len, i, q, mode;
    logic [7:0] b;
    while (items_sent < target) begin
      mode = $urandom_range(0, 9);
      len = (mode == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      for (i = 0; i < len; i++) begin
        case ($urandom_range(0, 5))
          0:       b = 8'($urandom);
          1:       b = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'hff;
          default: b = 8'h61 + 8'($urandom_range(0, 2));
        endcase
        send_word(1'b0, b, i == len - 1, AW'($urandom));
        if ($urandom_range(0, 30) == 0) send_word(1'b1, 8'($urandom), 1'b0, AW'($urandom));
      end
      q = $urandom_range(1, len + 3);
      for (i = 0; i < q; i++) begin
        if ($urandom_range(0, 5) == 0)
          send_word(1'b1, 8'($urandom), 1'b0, AW'($urandom));
        else
          send_word(1'b1, 8'($urandom), 1'b0, AW'($urandom_range(0, len - 1)));
      end
    end
  endtask

  // Result side: random stalls, with stretches of steady readiness and a few long holds.
  int ready_mode = 0;
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) ready_mode <= $urandom_range(0, 2);
    case (ready_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 19) == 0);
    endcase
  end

  always @(posedge clk) begin
    sa_word_t w;
    if (rst_n && out_valid && out_ready) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected word: status %0d", out_status);
      end else begin
        w = pending_words.pop_front();
        if (out_status !== w.status || out_suffix_start !== w.start ||
            out_bwt_symbol !== w.bwt || out_text_length !== w.len) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: exp st=%0d sa=%0d bwt=%02h len=%0d",
                     w.status, w.start, w.bwt, w.len);
            $display("          got st=%0d sa=%0d bwt=%02h len=%0d",
                     out_status, out_suffix_start, out_bwt_symbol, out_text_length);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    in_valid = 1'b0;
    in_func = 1'b0;
    in_symbol = '0;
    in_last = 1'b0;
    in_rank = '0;
    n_loaded = 0;
    built = 1'b0;
    items_sent = 0;
    builds_done = 0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(items_sent + 100);
    test_overflow();
    test_random(items_sent + 40);

    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Sent %0d items over %0d builds; %0d result words checked, %0d mismatches.",
             items_sent, builds_done, words_seen, mismatches);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
